>>> rtl/ols_pkg.sv
// Shared types and codes of the ordered list store.
`default_nettype none

package ols_pkg;

    localparam int VAL_W    = 32;
    localparam int OP_W     = 3;
    localparam int FPOS_W   = 5;
    localparam int LEN_W    = 5;
    localparam int STATUS_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_END   = 3'd1,
        OP_INS_POS   = 3'd2,
        OP_DEL_FRONT = 3'd3,
        OP_DEL_END   = 3'd4,
        OP_DUMP      = 3'd5
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_POS   = 2'd3
    } t_status;

    // Command broadcast to every cell of the chain.
    typedef enum logic [1:0] {
        CM_HOLD = 2'd0,
        CM_INS  = 2'd1,
        CM_SHL  = 2'd2
    } t_cell_mode;

endpackage

`default_nettype wire

>>> rtl/ols_ifs.sv
// Request and result channel interfaces of the ordered list store.
`default_nettype none

interface ols_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         operation;
    logic [4:0]         position;
    logic signed [31:0] value;

    modport source (output valid, operation, position, value, input ready);
    modport sink   (input valid, operation, position, value, output ready);
endinterface

interface ols_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] entry_value;
    logic [4:0]         list_length;
    logic [1:0]         status;
    logic               last;

    modport source (output valid, entry_value, list_length, status, last, input ready);
    modport sink   (input valid, entry_value, list_length, status, last, output ready);
endinterface

`default_nettype wire

>>> rtl/ols_cell.sv
// One storage cell of the list chain, holding a single entry.
`default_nettype none

module ols_cell #(
    parameter int IDX   = 0,
    parameter int POS_W = 5
) (
    input  wire logic                       i_clk,
    input  wire ols_pkg::t_cell_mode        i_mode,
    input  wire logic [POS_W-1:0]           i_pos,
    input  wire logic [ols_pkg::VAL_W-1:0]  i_data,
    input  wire logic [ols_pkg::VAL_W-1:0]  i_left,
    input  wire logic [ols_pkg::VAL_W-1:0]  i_right,
    output logic      [ols_pkg::VAL_W-1:0]  o_value
);
    import ols_pkg::*;

    localparam logic [POS_W-1:0] MY_IDX = POS_W'(IDX);

    logic [VAL_W-1:0] r_value;
    logic [VAL_W-1:0] n_value;

    // Insert opens a gap at the given position by moving later entries one place
    // up; a left shift closes the list towards the front and loads the given
    // position with the broadcast data.
    always_comb begin
        n_value = r_value;
        case (i_mode)
            CM_INS: begin
                if (MY_IDX > i_pos) begin
                    n_value = i_left;
                end else if (MY_IDX == i_pos) begin
                    n_value = i_data;
                end
            end
            CM_SHL: begin
                if (MY_IDX == i_pos) begin
                    n_value = i_data;
                end else if (MY_IDX < i_pos) begin
                    n_value = i_right;
                end
            end
            default: n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

`default_nettype wire

>>> rtl/ordered_list_store_top.sv
// Top level of the ordered list store: control sequencer, cell chain and result register.
`default_nettype none

// The ordered list store keeps up to DEPTH signed 32-bit values in a row of
// identical cells, entry 0 in the first cell, together with a count of the
// entries held. Each request carries one operation: insert at the front, at
// the end or at a given position, delete at the front or at the end, or dump.
// Every update answers with one result carrying the new length and a status
// (ok, list full, list empty, position beyond length); on any error the list
// is left untouched. An update acts on all cells at once in the cycle the
// request is taken, so with the result channel ready a new request can
// follow in the next cycle. A dump enters the dump state, then gives one
// result per stored entry: while the result register is free the chain
// rotates by one place, entry 0 going to the result register and to the
// tail, so count rotations restore the original order. The final result of a
// dump is marked by last; a dump of an empty list gives a single result with
// the empty status. No request is taken while a dump is running. Results
// pass through an output register, so a request can be taken while the
// previous result still waits, as long as that register is being emptied.
// Entries beyond the count are never read, so the cells need no reset.
module ordered_list_store_top #(
    parameter int DEPTH = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ols_req_if.sink    i_req,
    ols_res_if.source  o_res
);
    import ols_pkg::*;

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > FPOS_W) ? CW : FPOS_W;
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DUMP = 2'b10
    } t_state;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_k, n_k;

    logic               r_out_valid, n_out_valid;
    logic [VAL_W-1:0]   r_entry, n_entry;
    logic [LEN_W-1:0]   r_len, n_len;
    t_status            r_status, n_status;
    logic               r_last, n_last;

    t_cell_mode         w_mode;
    logic [CW-1:0]      w_pos;
    logic [VAL_W-1:0]   w_data;
    logic [VAL_W-1:0]   w_cell [DEPTH];

    logic               w_out_free;
    logic               w_accept;
    logic [CMPW-1:0]    w_ins_pos;
    logic [CMPW-1:0]    w_cnt_ext;
    logic               w_is_ins;
    logic               w_dump_last;

    // The chain of cells; the ends take their own value as the missing neighbour.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [VAL_W-1:0] w_left;
        logic [VAL_W-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = w_cell[g];
        end else begin : g_mid_l
            assign w_left = w_cell[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_right = w_cell[g];
        end else begin : g_mid_r
            assign w_right = w_cell[g+1];
        end

        ols_cell #(
            .IDX   (g),
            .POS_W (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_mode  (w_mode),
            .i_pos   (w_pos),
            .i_data  (w_data),
            .i_left  (w_left),
            .i_right (w_right),
            .o_value (w_cell[g])
        );
    end

    assign w_out_free  = !r_out_valid || o_res.ready;
    assign i_req.ready = (r_state == S_IDLE) && w_out_free;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_cnt_ext   = CMPW'(r_count);
    assign w_dump_last = (r_k == r_count - 1'b1);

    // Target index of an insert, widened so that it compares with the count.
    always_comb begin
        w_is_ins  = 1'b0;
        w_ins_pos = '0;
        case (t_op'(i_req.operation))
            OP_INS_FRONT: begin
                w_is_ins  = 1'b1;
                w_ins_pos = '0;
            end
            OP_INS_END: begin
                w_is_ins  = 1'b1;
                w_ins_pos = w_cnt_ext;
            end
            OP_INS_POS: begin
                w_is_ins  = 1'b1;
                w_ins_pos = CMPW'(i_req.position);
            end
            default: w_is_ins = 1'b0;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_k         = r_k;
        n_out_valid = r_out_valid;
        n_entry     = r_entry;
        n_len       = r_len;
        n_status    = r_status;
        n_last      = r_last;
        w_mode      = CM_HOLD;
        w_pos       = '0;
        w_data      = w_cell[0];

        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_status = ST_OK;
                    n_last   = 1'b1;
                    n_entry  = '0;
                    if (w_is_ins) begin
                        if (r_count == FULL_CNT) begin
                            n_status = ST_FULL;
                        end else if (w_ins_pos > w_cnt_ext) begin
                            n_status = ST_POS;
                        end else begin
                            w_mode  = CM_INS;
                            w_pos   = CW'(w_ins_pos);
                            w_data  = i_req.value;
                            n_count = r_count + 1'b1;
                        end
                    end else begin
                        case (t_op'(i_req.operation))
                            OP_DEL_FRONT: begin
                                if (r_count == '0) begin
                                    n_status = ST_EMPTY;
                                end else begin
                                    // Close up towards the front; the tail slot
                                    // takes a copy that falls outside the count.
                                    w_mode  = CM_SHL;
                                    w_pos   = r_count - 1'b1;
                                    n_count = r_count - 1'b1;
                                end
                            end
                            OP_DEL_END: begin
                                if (r_count == '0) begin
                                    n_status = ST_EMPTY;
                                end else begin
                                    n_count = r_count - 1'b1;
                                end
                            end
                            OP_DUMP: begin
                                if (r_count == '0) begin
                                    n_status = ST_EMPTY;
                                end
                            end
                            default: n_status = ST_OK;
                        endcase
                    end

                    if ((t_op'(i_req.operation) == OP_DUMP) && (r_count != '0)) begin
                        // The entries follow from the dump state.
                        n_state = S_DUMP;
                        n_k     = '0;
                    end else begin
                        n_out_valid = 1'b1;
                        n_len       = LEN_W'(n_count);
                    end
                end
            end
            S_DUMP: begin
                if (w_out_free) begin
                    // Emit the head entry and rotate it to the tail of the list.
                    n_out_valid = 1'b1;
                    n_entry     = w_cell[0];
                    n_len       = LEN_W'(r_count);
                    n_status    = ST_OK;
                    n_last      = w_dump_last;
                    w_mode      = CM_SHL;
                    w_pos       = r_count - 1'b1;
                    w_data      = w_cell[0];
                    n_k         = r_k + 1'b1;
                    if (w_dump_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry  <= n_entry;
        r_len    <= n_len;
        r_status <= n_status;
        r_last   <= n_last;
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.entry_value = r_entry;
    assign o_res.list_length = r_len;
    assign o_res.status      = r_status;
    assign o_res.last        = r_last;

endmodule

`default_nettype wire
